[hdl/rex_pkg.sv]
package rex_pkg;

  // Field widths shared across the block.
  localparam int unsigned MapW   = 6;
  localparam int unsigned FracW  = 17;

  // Shared multiplier operand and product widths.
  localparam int unsigned MulAW  = 26;
  localparam int unsigned MulBW  = 18;
  localparam int unsigned MulPW  = MulAW + MulBW;

  // log2(e) in Q.16 and the shift at which the exponential is zero.
  localparam logic [MulBW-1:0] Log2eQ16 = 18'd94548;
  localparam logic [MapW-1:0]  ExpShiftMax = 6'd17;

  typedef enum logic [1:0] {
    CmdWrBeta   = 2'd0,
    CmdWrEnergy = 2'd1,
    CmdExchange = 2'd2,
    CmdReadMap  = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    StIdle,
    StWrTab,
    StRdMap,
    StMapCap,
    StRdLo,
    StRdHi,
    StRdE1,
    StRdE2,
    StDe,
    StMulLo,
    StMulHi,
    StSum,
    StExpM,
    StExpV,
    StDec,
    StWr1,
    StWr2,
    StDone
  } state_e;

  // Access request to one of the temperature/replica map memories.
  typedef struct packed {
    logic            we;
    logic [MapW-1:0] waddr;
    logic [MapW-1:0] wdata;
    logic [MapW-1:0] raddr;
  } map_req_t;

  typedef logic [255:0][FracW-1:0] frac_tab_t;

  // The constants 2^(-2^k/256) in Q0.32.
  function automatic logic [63:0] root_const(input int unsigned k);
    logic [63:0] r;
    case (k)
      0:       r = 64'd4283353945;
      1:       r = 64'd4271771996;
      2:       r = 64'd4248701965;
      3:       r = 64'd4202935003;
      4:       r = 64'd4112874773;
      5:       r = 64'd3938502376;
      6:       r = 64'd3611622603;
      default: r = 64'd3037000500;
    endcase
    return r;
  endfunction

  // Fraction table: 65536 * 2^(-f/256), built as a truncated product of roots.
  function automatic frac_tab_t build_frac_table();
    frac_tab_t   t;
    logic [63:0] v;
    for (int unsigned i = 0; i < 256; i++) begin
      v = 64'h1_0000_0000;
      for (int unsigned k = 0; k < 8; k++) begin
        if (((i >> k) & 1) != 0) begin
          v = (v * root_const(k)) >> 32;
        end
      end
      t[i] = FracW'((v + 64'd32768) >> 16);
    end
    return t;
  endfunction

  localparam frac_tab_t FracTable = build_frac_table();

endpackage

[hdl/replica_exchange_swap_step.sv]
// Words are taken one at a time, and no new word is taken until the result of the last
// one is in the output register; an exchange walks the table read ports, the shared
// multiplier and the map write-back in turn.
// Reset: asynchronous, active low; the temperature/replica maps read as identity,
// the beta and energy tables are undefined until written.
module replica_exchange_swap_step #(
  parameter int unsigned REPLICAS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic [5:0]         index_i,
  input  logic signed [31:0] value_i,
  input  logic [15:0]        uniform_random_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               swapped_o,
  output logic [5:0]         replica_low_o,
  output logic [5:0]         replica_high_o,
  output logic [5:0]         temperature_of_replica_o
);

  localparam int unsigned IW = $clog2(REPLICAS);
  localparam int unsigned MW = rex_pkg::MapW;
  localparam int unsigned FW = rex_pkg::FracW;
  localparam int unsigned AW = rex_pkg::MulAW;
  localparam int unsigned BW = rex_pkg::MulBW;
  localparam int unsigned PW = rex_pkg::MulPW;

  rex_pkg::state_e state_q, state_d;

  // Latched input word.
  rex_pkg::cmd_e   cmd_q;
  logic [MW-1:0]   idx_q;
  logic [31:0]     value_q;
  logic [15:0]     rnd_q;

  // Exchange working registers.
  logic [MW-1:0]        r1_q, r2_q, rt_q;
  logic [15:0]          beta_lo_q, beta_hi_q;
  logic [31:0]          e1_q;
  logic signed [16:0]   db_q;
  logic signed [32:0]   de_q;
  logic signed [33:0]   plo_q;
  logic signed [49:0]   x_q;
  logic                 big_q;
  logic [FW-1:0]        val_q;
  logic                 take_q;

  // Output register.
  logic          out_valid_q;
  logic          swapped_q;
  logic [MW-1:0] low_q, high_q, temp_q;

  logic          in_acc;
  logic          out_free;
  logic          in_range;
  logic          ex_ok;
  logic [MW-1:0] lo_idx;

  // Memory ports.
  logic                beta_we, energy_we;
  logic [IW-1:0]       beta_raddr, energy_raddr;
  logic [15:0]         beta_rdata;
  logic [31:0]         energy_rdata;
  rex_pkg::map_req_t   t2r_req, r2t_req;
  logic [MW-1:0]       t2r_rdata, r2t_rdata;

  // Shared multiplier ports.
  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;

  // Datapath helpers.
  logic signed [32:0]   de_d;
  logic signed [49:0]   x_d;
  logic signed [49:0]   m_neg;
  logic [21:0]          log_q16;
  logic [MW-1:0]        exp_shift;
  logic [FW-1:0]        val_d;
  logic                 take_d;

  logic          res_swapped;
  logic [MW-1:0] res_low, res_high, res_temp;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign in_range = {1'b0, idx_q} < (MW + 1)'(REPLICAS);
  assign ex_ok    = in_range && (idx_q != '0);
  assign lo_idx   = idx_q - MW'(1);

  rex_ram #(.DEPTH(REPLICAS), .WIDTH(16)) u_beta (
    .clk_i   (clk_i),
    .we_i    (beta_we),
    .waddr_i (idx_q[IW-1:0]),
    .wdata_i (value_q[15:0]),
    .raddr_i (beta_raddr),
    .rdata_o (beta_rdata)
  );

  rex_ram #(.DEPTH(REPLICAS), .WIDTH(32)) u_energy (
    .clk_i   (clk_i),
    .we_i    (energy_we),
    .waddr_i (idx_q[IW-1:0]),
    .wdata_i (value_q),
    .raddr_i (energy_raddr),
    .rdata_o (energy_rdata)
  );

  rex_map #(.REPLICAS(REPLICAS)) u_t2r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (t2r_req),
    .rdata_o (t2r_rdata)
  );

  rex_map #(.REPLICAS(REPLICAS)) u_r2t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (r2t_req),
    .rdata_o (r2t_rdata)
  );

  rex_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rex_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer: next state, memory accesses and multiplier operands.
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    beta_we      = 1'b0;
    energy_we    = 1'b0;
    beta_raddr   = '0;
    energy_raddr = '0;
    t2r_req      = '0;
    r2t_req      = '0;
    mul_a        = '0;
    mul_b        = '0;
    m_neg        = -x_q;
    case (state_q)
      rex_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (rex_pkg::cmd_e'(cmd_i))
            rex_pkg::CmdExchange: state_d = rex_pkg::StRdLo;
            rex_pkg::CmdReadMap:  state_d = rex_pkg::StRdMap;
            default:              state_d = rex_pkg::StWrTab;
          endcase
        end
      end
      rex_pkg::StWrTab: begin
        beta_we   = in_range && (cmd_q == rex_pkg::CmdWrBeta);
        energy_we = in_range && (cmd_q == rex_pkg::CmdWrEnergy);
        state_d   = rex_pkg::StDone;
      end
      rex_pkg::StRdMap: begin
        t2r_req.raddr = idx_q;
        r2t_req.raddr = idx_q;
        state_d       = rex_pkg::StMapCap;
      end
      rex_pkg::StMapCap: begin
        state_d = rex_pkg::StDone;
      end
      rex_pkg::StRdLo: begin
        t2r_req.raddr = lo_idx;
        beta_raddr    = lo_idx[IW-1:0];
        state_d       = ex_ok ? rex_pkg::StRdHi : rex_pkg::StDone;
      end
      rex_pkg::StRdHi: begin
        t2r_req.raddr = idx_q;
        beta_raddr    = idx_q[IW-1:0];
        state_d       = rex_pkg::StRdE1;
      end
      rex_pkg::StRdE1: begin
        energy_raddr = r1_q[IW-1:0];
        state_d      = rex_pkg::StRdE2;
      end
      rex_pkg::StRdE2: begin
        energy_raddr = r2_q[IW-1:0];
        state_d      = rex_pkg::StDe;
      end
      rex_pkg::StDe: begin
        state_d = rex_pkg::StMulLo;
      end
      rex_pkg::StMulLo: begin
        // Low 16 bits of the energy difference, taken as unsigned.
        mul_a   = $signed({10'b0, de_q[15:0]});
        mul_b   = {db_q[16], db_q};
        state_d = rex_pkg::StMulHi;
      end
      rex_pkg::StMulHi: begin
        mul_a   = {{(AW - 17){de_q[32]}}, de_q[32:16]};
        mul_b   = {db_q[16], db_q};
        state_d = rex_pkg::StSum;
      end
      rex_pkg::StSum: begin
        state_d = rex_pkg::StExpM;
      end
      rex_pkg::StExpM: begin
        // Scale the magnitude by log2(e) to get a power of two.
        mul_a   = $signed({1'b0, m_neg[24:0]});
        mul_b   = $signed(rex_pkg::Log2eQ16);
        state_d = rex_pkg::StExpV;
      end
      rex_pkg::StExpV: begin
        state_d = rex_pkg::StDec;
      end
      rex_pkg::StDec: begin
        state_d = rex_pkg::StWr1;
      end
      rex_pkg::StWr1: begin
        t2r_req.we    = take_q;
        t2r_req.waddr = idx_q;
        t2r_req.wdata = r1_q;
        r2t_req.we    = take_q;
        r2t_req.waddr = r1_q;
        r2t_req.wdata = idx_q;
        state_d       = rex_pkg::StWr2;
      end
      rex_pkg::StWr2: begin
        t2r_req.we    = take_q;
        t2r_req.waddr = lo_idx;
        t2r_req.wdata = r2_q;
        r2t_req.we    = take_q;
        r2t_req.waddr = r2_q;
        r2t_req.wdata = lo_idx;
        state_d       = rex_pkg::StDone;
      end
      rex_pkg::StDone: begin
        if (out_free) begin
          state_d = rex_pkg::StIdle;
        end
      end
      default: begin
        state_d = rex_pkg::StIdle;
      end
    endcase
  end

  // Energy difference, product recombination, exponential lookup and swap decision.
  always_comb begin
    de_d      = $signed({energy_rdata[31], energy_rdata}) - $signed({e1_q[31], e1_q});
    x_d       = $signed({mul_p[33:0], 16'b0}) + 50'(plo_q);
    log_q16   = mul_p[41:20];
    exp_shift = log_q16[21:16];
    if (exp_shift >= rex_pkg::ExpShiftMax) begin
      val_d = '0;
    end else begin
      val_d = rex_pkg::FracTable[log_q16[15:8]] >> exp_shift;
    end
    take_d = de_q[32] || !x_q[49] || (!big_q && ({1'b0, rnd_q} < val_q));
  end

  // Swap decision flag; cleared for every new word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      take_q <= 1'b0;
    end else if (in_acc) begin
      take_q <= 1'b0;
    end else if (state_q == rex_pkg::StDec) begin
      take_q <= take_d;
    end
  end

  // Input latch and working registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= rex_pkg::cmd_e'(cmd_i);
      idx_q   <= index_i;
      value_q <= value_i;
      rnd_q   <= uniform_random_i;
    end
    case (state_q)
      rex_pkg::StMapCap: begin
        r1_q <= t2r_rdata;
        rt_q <= r2t_rdata;
      end
      rex_pkg::StRdHi: begin
        r1_q      <= t2r_rdata;
        beta_lo_q <= beta_rdata;
      end
      rex_pkg::StRdE1: begin
        r2_q      <= t2r_rdata;
        beta_hi_q <= beta_rdata;
      end
      rex_pkg::StRdE2: begin
        e1_q <= energy_rdata;
        db_q <= $signed({1'b0, beta_hi_q}) - $signed({1'b0, beta_lo_q});
      end
      rex_pkg::StDe: begin
        de_q <= de_d;
      end
      rex_pkg::StMulHi: begin
        plo_q <= mul_p[33:0];
      end
      rex_pkg::StSum: begin
        x_q <= x_d;
      end
      rex_pkg::StExpM: begin
        big_q <= |m_neg[49:25];
      end
      rex_pkg::StExpV: begin
        val_q <= val_d;
      end
      default: begin
      end
    endcase
  end

  // Result word by command.
  always_comb begin
    res_swapped = 1'b0;
    res_low     = '0;
    res_high    = '0;
    res_temp    = '0;
    case (cmd_q)
      rex_pkg::CmdExchange: begin
        if (ex_ok) begin
          res_swapped = take_q;
          res_low     = take_q ? r2_q : r1_q;
          res_high    = take_q ? r1_q : r2_q;
        end
      end
      rex_pkg::CmdReadMap: begin
        if (in_range) begin
          res_low  = r1_q;
          res_temp = rt_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register parts the result from the next word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == rex_pkg::StDone && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rex_pkg::StDone && out_free) begin
      swapped_q <= res_swapped;
      low_q     <= res_low;
      high_q    <= res_high;
      temp_q    <= res_temp;
    end
  end

  assign out_valid_o              = out_valid_q;
  assign swapped_o                = swapped_q;
  assign replica_low_o            = low_q;
  assign replica_high_o           = high_q;
  assign temperature_of_replica_o = temp_q;

`ifndef ASSERT_OFF
  // A word in work blocks the input until its result is formed.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("input taken while a word is in work");

  // A swap always exchanges two distinct replicas.
  a_swap_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && swapped_o) |-> (replica_low_o != replica_high_o))
    else $error("swap reported between identical replicas");

  // Map updates happen only in the write-back steps of a taken swap.
  a_map_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t2r_req.we || r2t_req.we) |->
      (take_q && (state_q == rex_pkg::StWr1 || state_q == rex_pkg::StWr2)))
    else $error("map written outside a taken swap");
`endif

endmodule

[hdl/rex_ram.sv]
module rex_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/rex_map.sv]
module rex_map #(
  parameter int unsigned REPLICAS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rex_pkg::map_req_t              req_i,
  output logic [rex_pkg::MapW-1:0]       rdata_o
);

  localparam int unsigned IW = $clog2(REPLICAS);

  logic [REPLICAS-1:0]      vld_q;
  logic                     rd_vld_q;
  logic [IW-1:0]            raddr_q;
  logic [rex_pkg::MapW-1:0] ram_rdata;

  rex_ram #(
    .DEPTH(REPLICAS),
    .WIDTH(rex_pkg::MapW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr[IW-1:0]),
    .wdata_i (req_i.wdata),
    .raddr_i (req_i.raddr[IW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Valid bits mark entries written since reset; others still hold identity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr[IW-1:0]] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.raddr[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= req_i.raddr[IW-1:0];
  end

  // An entry never written reads as its own index.
  assign rdata_o = rd_vld_q ? ram_rdata : rex_pkg::MapW'(raddr_q);

endmodule

[hdl/rex_mul.sv]
module rex_mul (
  input  logic                              clk_i,
  input  logic signed [rex_pkg::MulAW-1:0]  a_i,
  input  logic signed [rex_pkg::MulBW-1:0]  b_i,
  output logic signed [rex_pkg::MulPW-1:0]  prod_o
);

  logic signed [rex_pkg::MulPW-1:0] prod_q;

  // Shared signed multiplier with the product registered.
  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

[tb/sv/tb.sv]
module tb;

  localparam int NREP = 16;
  localparam int RANDOM_WORDS = 2000;
  localparam int WATCHDOG_LIMIT = 600;
  localparam int END_WAIT = 30;
  localparam longint unsigned LOG2E_Q16 = 94548;
  localparam longint unsigned EXP_FLOOR_Q20 = 64'd32 << 20;

  // One result word, in port order.
  typedef struct packed {
    logic       swapped;
    logic [5:0] low;
    logic [5:0] high;
    logic [5:0] temp;
  } result_t;

  // One row of the directed table; typed rows carry their own expectation.
  typedef struct packed {
    rex_pkg::cmd_e cmd;
    logic [5:0]    idx;
    logic [31:0]   val;
    logic [15:0]   rnd;
    logic          typed;
    result_t       want;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         cmd_i;
  logic [5:0]         index_i;
  logic signed [31:0] value_i;
  logic [15:0]        uniform_random_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               swapped_o;
  logic [5:0]         replica_low_o;
  logic [5:0]         replica_high_o;
  logic [5:0]         temperature_of_replica_o;

  // Predictor state: tables, written flags and the two-way map.
  logic [15:0]        beta_q [NREP];
  logic signed [31:0] energy_q [NREP];
  bit                 beta_set [NREP];
  bit                 energy_set [NREP];
  logic [5:0]         t2r [NREP];
  logic [5:0]         r2t [NREP];
  int unsigned        frac_tab [256];

  result_t     pending [$];
  row_t        rows [$];
  int          mismatches = 0;
  int          idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          no_idle = 1'b0;

  replica_exchange_swap_step #(
    .REPLICAS(NREP)
  ) dut (
    .clk_i                    (clk_i),
    .rst_ni                   (rst_ni),
    .in_valid_i               (in_valid_i),
    .in_ready_o               (in_ready_o),
    .cmd_i                    (cmd_i),
    .index_i                  (index_i),
    .value_i                  (value_i),
    .uniform_random_i         (uniform_random_i),
    .out_valid_o              (out_valid_o),
    .out_ready_i              (out_ready_i),
    .swapped_o                (swapped_o),
    .replica_low_o            (replica_low_o),
    .replica_high_o           (replica_high_o),
    .temperature_of_replica_o (temperature_of_replica_o)
  );

  always #4 clk_i = ~clk_i;

  // The constants 2^(-2^k/256) in Q0.32.
  function automatic longint unsigned root_q32(int k);
    case (k)
      0: return 64'd4283353945;
      1: return 64'd4271771996;
      2: return 64'd4248701965;
      3: return 64'd4202935003;
      4: return 64'd4112874773;
      5: return 64'd3938502376;
      6: return 64'd3611622603;
      default: return 64'd3037000500;
    endcase
  endfunction

  // exp(x) in Q1.16 for x in Q.20, as a power of two with a fraction table.
  function automatic int unsigned exp_fixed(longint x);
    longint unsigned m;
    longint unsigned l;
    longint unsigned n;
    if (x >= 0) return 65536;
    m = -x;
    if (m >= EXP_FLOOR_Q20) return 0;
    l = (m * LOG2E_Q16) >> 20;
    n = l >> 16;
    if (n >= 17) return 0;
    return frac_tab[(l >> 8) & 255] >> n;
  endfunction

  // Apply one word to the predictor state and return the result it should give.
  function automatic result_t predict_word(rex_pkg::cmd_e c, logic [5:0] idx,
                                           logic [31:0] val, logic [15:0] rnd);
    result_t     r;
    int unsigned lo;
    logic [5:0]  r1;
    logic [5:0]  r2;
    longint      db;
    longint      de;
    bit          take;
    r = '0;
    case (c)
      rex_pkg::CmdWrBeta: begin
        if (idx < NREP) begin
          beta_q[idx] = val[15:0];
          beta_set[idx] = 1'b1;
        end
      end
      rex_pkg::CmdWrEnergy: begin
        if (idx < NREP) begin
          energy_q[idx] = val;
          energy_set[idx] = 1'b1;
        end
      end
      rex_pkg::CmdExchange: begin
        if (idx >= 1 && idx < NREP) begin
          lo = idx - 1;
          r1 = t2r[lo];
          r2 = t2r[idx];
          db = longint'(beta_q[idx]) - longint'(beta_q[lo]);
          de = longint'(energy_q[r2]) - longint'(energy_q[r1]);
          take = (de < 0) || (32'(rnd) < exp_fixed(db * de));
          if (take) begin
            t2r[idx] = r1;
            r2t[r1] = idx;
            t2r[lo] = r2;
            r2t[r2] = 6'(lo);
          end
          r.swapped = take;
          r.low = t2r[lo];
          r.high = t2r[idx];
        end
      end
      default: begin
        if (idx < NREP) begin
          r.low = t2r[idx];
          r.temp = r2t[idx];
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_row(rex_pkg::cmd_e c, logic [5:0] idx, logic [31:0] val,
                                  logic [15:0] rnd, logic typed, logic sw, logic [5:0] lo,
                                  logic [5:0] hi, logic [5:0] tmp);
    row_t rw;
    rw.cmd = c;
    rw.idx = idx;
    rw.val = val;
    rw.rnd = rnd;
    rw.typed = typed;
    rw.want = '{swapped: sw, low: lo, high: hi, temp: tmp};
    rows.push_back(rw);
  endfunction

  task automatic log_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Drive one word after a random gap and hold it until it is accepted.
  task automatic send_word(rex_pkg::cmd_e c, logic [5:0] idx, logic [31:0] val,
                           logic [15:0] rnd, result_t want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= c;
    index_i <= idx;
    value_i <= val;
    uniform_random_i <= rnd;
    do @(posedge clk_i); while (!in_ready_o);
    pending.push_back(want);
  endtask

  // Stop sending and wait until every pending result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus: directed table first, then random words.
  initial begin : stimulus
    row_t            rw;
    result_t         want;
    rex_pkg::cmd_e   c;
    logic [5:0]      idx;
    logic [31:0]     val;
    logic [15:0]     rnd;
    int unsigned     t;
    int unsigned     pick;
    longint unsigned v;

    in_valid_i = 1'b0;
    cmd_i = rex_pkg::CmdWrBeta;
    index_i = '0;
    value_i = '0;
    uniform_random_i = '0;
    rst_ni = 1'b0;

    // Fraction table and the predictor's view of reset.
    for (int i = 0; i < 256; i++) begin
      v = 64'h1_0000_0000;
      for (int k = 0; k < 8; k++) begin
        if (((i >> k) & 1) != 0) v = (v * root_q32(k)) >> 32;
      end
      frac_tab[i] = int'((v + 64'd32768) >> 16);
    end
    for (int i = 0; i < NREP; i++) begin
      t2r[i] = 6'(i);
      r2t[i] = 6'(i);
      beta_q[i] = '0;
      energy_q[i] = '0;
      beta_set[i] = 1'b0;
      energy_set[i] = 1'b0;
    end

    // Map reads and out-of-range words right after reset.
    add_row(rex_pkg::CmdReadMap, 6'd0, 32'd0, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdReadMap, 6'd15, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b0, 6'd15, 6'd0,
            6'd15);
    add_row(rex_pkg::CmdReadMap, 6'd63, 32'd0, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd0, 32'd0, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd16, 32'd0, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    // Beta and energy extremes, plus ignored writes beyond the table.
    add_row(rex_pkg::CmdWrBeta, 6'd0, 32'h0000_0000, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrBeta, 6'd1, 32'hFFFF_FFFF, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrBeta, 6'd63, 32'h0000_1234, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrEnergy, 6'd0, 32'h8000_0000, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrEnergy, 6'd1, 32'h7FFF_FFFF, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrEnergy, 6'd40, 32'h5A5A_5A5A, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    // Positive exponent swaps even at the largest random; negative energy step swaps back.
    add_row(rex_pkg::CmdExchange, 6'd1, 32'd0, 16'hFFFF, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdReadMap, 6'd0, 32'd0, 16'd0, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd1, 32'd0, 16'd0, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrEnergy, 6'd16, 32'd7, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    // Exponent near exp(-1): swap at random 0, then the negative energy step swaps back,
    // then the largest random refuses.
    add_row(rex_pkg::CmdWrBeta, 6'd2, 32'h0000_F000, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrEnergy, 6'd1, 32'h0000_0100, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrEnergy, 6'd2, 32'h0000_0200, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd2, 32'd0, 16'd0, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd2, 32'd0, 16'hFFFF, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd2, 32'd0, 16'hFFFF, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);
    // Exponential saturated to zero: no swap even at random 0.
    add_row(rex_pkg::CmdWrBeta, 6'd0, 32'h0000_FFFF, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdWrBeta, 6'd1, 32'h0000_0000, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd1, 32'd0, 16'd0, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);
    // Equal energies give exponent zero, which always swaps.
    add_row(rex_pkg::CmdWrEnergy, 6'd0, 32'h0000_0100, 16'd0, 1'b1, 1'b0, 6'd0, 6'd0, 6'd0);
    add_row(rex_pkg::CmdExchange, 6'd1, 32'd0, 16'hFFFF, 1'b0, 1'b0, 6'd0, 6'd0, 6'd0);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      rw = rows[i];
      want = predict_word(rw.cmd, rw.idx, rw.val, rw.rnd);
      if (rw.typed) want = rw.want;
      send_word(rw.cmd, rw.idx, rw.val, rw.rnd, want);
    end
    drain_results();

    // Random words: exchanges between written entries, out-of-range exchanges, table writes and map reads.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 500 == 250) drain_results();
      val = $urandom;
      rnd = 16'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        // An exchange whose operands are not written yet becomes the missing write.
        t = $urandom_range(1, NREP - 1);
        c = rex_pkg::CmdExchange;
        idx = 6'(t);
        if (!beta_set[t]) begin
          c = rex_pkg::CmdWrBeta;
        end else if (!beta_set[t-1]) begin
          c = rex_pkg::CmdWrBeta;
          idx = 6'(t - 1);
        end else if (!energy_set[t2r[t]]) begin
          c = rex_pkg::CmdWrEnergy;
          idx = t2r[t];
        end else if (!energy_set[t2r[t-1]]) begin
          c = rex_pkg::CmdWrEnergy;
          idx = t2r[t-1];
        end
        case ($urandom_range(0, 7))
          0: rnd = 16'h0000;
          1: rnd = 16'hFFFF;
          default: ;
        endcase
        if (c == rex_pkg::CmdWrBeta) val[15:0] = 16'($urandom_range(16'h0800, 16'h1800));
        if (c == rex_pkg::CmdWrEnergy) val = $urandom >> $urandom_range(8, 31);
      end else if (pick < 47) begin
        c = rex_pkg::CmdExchange;
        idx = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(NREP, 63));
      end else begin
        if (pick < 65) c = rex_pkg::CmdWrBeta;
        else if (pick < 83) c = rex_pkg::CmdWrEnergy;
        else c = rex_pkg::CmdReadMap;
        idx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(NREP, 63))
                                           : 6'($urandom_range(0, NREP - 1));
        // Betas close together and small energies keep the exponent in range.
        if (c == rex_pkg::CmdWrBeta && $urandom_range(0, 2) != 0) begin
          val[15:0] = 16'($urandom_range(16'h0800, 16'h1800));
        end
        if (c == rex_pkg::CmdWrEnergy && $urandom_range(0, 3) != 0) begin
          val = $urandom >> $urandom_range(8, 31);
          if ($urandom_range(0, 1) == 0) val = -val;
        end
      end
      want = predict_word(c, idx, val, rnd);
      send_word(c, idx, val, rnd, want);
    end

    drain_results();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: hold ready low for a random stall after each word.
  initial begin : result_sink
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 6);
      if (pending.size() == 0) begin
        log_mismatch("result word with no pending expectation");
      end else begin
        want = pending.pop_front();
        if (swapped_o !== want.swapped)
          log_mismatch($sformatf("swapped %b, expected %b", swapped_o, want.swapped));
        if (replica_low_o !== want.low)
          log_mismatch($sformatf("replica_low %0d, expected %0d", replica_low_o, want.low));
        if (replica_high_o !== want.high)
          log_mismatch($sformatf("replica_high %0d, expected %0d", replica_high_o, want.high));
        if (temperature_of_replica_o !== want.temp)
          log_mismatch($sformatf("temperature_of_replica %0d, expected %0d",
                                 temperature_of_replica_o, want.temp));
      end
    end
  end

  // Watchdog: too many cycles without a word moving on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule

[filelist.f]
hdl/rex_pkg.sv
hdl/rex_ram.sv
hdl/rex_map.sv
hdl/rex_mul.sv
hdl/replica_exchange_swap_step.sv
tb/sv/tb.sv
